// ----- rtl/core/srle_pkg.sv -----
// Shared types and constants for the run-length splash image blitter
package srle_pkg;

  // configuration register indexes (byte address is four times the index)
  localparam int unsigned PADDR_W = 5;
  localparam logic [2:0] REG_POS_X         = 3'd0;
  localparam logic [2:0] REG_POS_Y         = 3'd1;
  localparam logic [2:0] REG_FRAME_COLUMNS = 3'd2;
  localparam logic [2:0] REG_FRAME_LINES   = 3'd3;
  localparam logic [2:0] REG_DOUBLE_SIZE   = 3'd4;

  // register reset values
  localparam logic [11:0] FRAME_COLUMNS_RST = 12'd720;
  localparam logic [11:0] FRAME_LINES_RST   = 12'd1280;

  // header layout
  localparam logic [4:0] HEADER_BYTES  = 5'd16;
  localparam logic [4:0] HDR_MAGIC0    = 5'd0;
  localparam logic [4:0] HDR_MAGIC1    = 5'd1;
  localparam logic [4:0] HDR_BPD       = 5'd4;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd6;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd7;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd8;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd9;
  localparam logic [7:0] MAGIC0        = 8'h53;
  localparam logic [7:0] MAGIC1        = 8'h52;
  localparam logic [7:0] BYTES_PER_DOT = 8'd2;

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_FLAG   = 8'b0000_0010,
    PH_COUNT  = 8'b0000_0100,
    PH_RLOW   = 8'b0000_1000,
    PH_RHIGH  = 8'b0001_0000,
    PH_XLOW   = 8'b0010_0000,
    PH_XHIGH  = 8'b0100_0000,
    PH_IDLE   = 8'b1000_0000
  } phase_t;

  // input item
  typedef struct packed {
    logic [7:0] image_byte;
    logic       first_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [23:0] dest_index;
    logic [12:0] run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        header_error;
    logic        last_of_run;
  } out_item_t;

  // decoded pixel run from the parser
  typedef struct packed {
    logic        err;
    logic [16:0] c0;
    logic [7:0]  count;
    logic [15:0] pix;
    logic [15:0] row;
    logic [15:0] width;
  } req_t;

  // clipped run in frame coordinates
  typedef struct packed {
    logic        err;
    logic [11:0] line;
    logic [11:0] col;
    logic [11:0] len;
    logic [15:0] pix;
  } run_t;

endpackage

// ----- rtl/core/srle_parse.sv -----
// Byte parser: header check and line decode into pixel run requests
module srle_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  srle_pkg::in_item_t in_item,
  output logic             req_valid,
  output srle_pkg::req_t   req,
  input  logic             req_ready
);
  import srle_pkg::*;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [4:0]  hcount_r, hcount_nxt, cur_hc, hc_inc;
  logic        dots_ok_r, dots_ok_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] row_r, row_nxt, row_inc;
  logic [16:0] col_r, col_nxt, col_run, col_one;
  logic [7:0]  run_cnt_r, run_cnt_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        req_valid_r;
  req_t        req_r, req_nxt;
  logic        emit;
  logic        accept;
  logic [7:0]  b;
  phase_t      end_phase;

  assign in_stall  = req_valid_r && !req_ready;
  assign accept    = in_valid && !in_stall;
  assign req_valid = req_valid_r;
  assign req       = req_r;

  // next parser state for the byte on the input
  always_comb begin
    b          = in_item.image_byte;
    cur_phase  = in_item.first_byte ? PH_HEADER : phase_r;
    cur_hc     = in_item.first_byte ? 5'd0 : hcount_r;
    hc_inc     = cur_hc + 5'd1;
    col_run    = col_r + {9'd0, run_cnt_r};
    col_one    = col_r + 17'd1;
    row_inc    = row_r + 16'd1;
    end_phase  = (row_inc >= height_r) ? PH_IDLE : PH_FLAG;

    phase_nxt   = phase_r;
    hcount_nxt  = hcount_r;
    dots_ok_nxt = dots_ok_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    run_cnt_nxt = run_cnt_r;
    low_nxt     = low_r;
    emit        = 1'b0;

    req_nxt.err   = 1'b0;
    req_nxt.c0    = col_r;
    req_nxt.count = run_cnt_r;
    req_nxt.pix   = {b, low_r};
    req_nxt.row   = row_r;
    req_nxt.width = width_r;

    case (cur_phase)
      PH_HEADER: begin
        phase_nxt  = PH_HEADER;
        hcount_nxt = hc_inc;
        case (cur_hc)
          HDR_MAGIC0:    dots_ok_nxt = (b == MAGIC0);
          HDR_MAGIC1:    dots_ok_nxt = dots_ok_r && (b == MAGIC1);
          HDR_BPD:       dots_ok_nxt = dots_ok_r && (b == BYTES_PER_DOT);
          HDR_WIDTH_LO:  width_nxt   = {8'd0, b};
          HDR_WIDTH_HI:  width_nxt   = {b, width_r[7:0]};
          HDR_HEIGHT_LO: height_nxt  = {8'd0, b};
          HDR_HEIGHT_HI: height_nxt  = {b, height_r[7:0]};
          default: ;
        endcase
        // header complete
        if (hc_inc >= HEADER_BYTES) begin
          row_nxt = 16'd0;
          col_nxt = 17'd0;
          if (!dots_ok_nxt) begin
            emit          = 1'b1;
            req_nxt.err   = 1'b1;
            req_nxt.c0    = 17'd0;
            req_nxt.count = 8'd0;
            req_nxt.pix   = 16'd0;
            req_nxt.row   = 16'd0;
            req_nxt.width = 16'd0;
            phase_nxt     = PH_IDLE;
          end else begin
            phase_nxt = (height_r == 16'd0) ? PH_IDLE : PH_FLAG;
          end
        end
      end
      PH_FLAG: begin
        col_nxt = 17'd0;
        if (b == 8'd0) begin
          // raw row; an empty raw row ends at its flag
          if (width_r == 16'd0) begin
            row_nxt   = row_inc;
            phase_nxt = end_phase;
          end else begin
            phase_nxt = PH_XLOW;
          end
        end else begin
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        run_cnt_nxt = b;
        phase_nxt   = PH_RLOW;
      end
      PH_RLOW: begin
        low_nxt   = b;
        phase_nxt = PH_RHIGH;
      end
      PH_RHIGH: begin
        emit = (run_cnt_r != 8'd0);
        if (col_run >= {1'b0, width_r}) begin
          row_nxt   = row_inc;
          col_nxt   = 17'd0;
          phase_nxt = end_phase;
        end else begin
          col_nxt   = col_run;
          phase_nxt = PH_COUNT;
        end
      end
      PH_XLOW: begin
        low_nxt   = b;
        phase_nxt = PH_XHIGH;
      end
      PH_XHIGH: begin
        emit          = 1'b1;
        req_nxt.count = 8'd1;
        if (col_one >= {1'b0, width_r}) begin
          row_nxt   = row_inc;
          col_nxt   = 17'd0;
          phase_nxt = end_phase;
        end else begin
          col_nxt   = col_one;
          phase_nxt = PH_XLOW;
        end
      end
      PH_IDLE: ;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // parser state and request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hcount_r    <= 5'd0;
      dots_ok_r   <= 1'b0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      row_r       <= 16'd0;
      col_r       <= 17'd0;
      run_cnt_r   <= 8'd0;
      low_r       <= 8'd0;
      req_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        hcount_r  <= hcount_nxt;
        dots_ok_r <= dots_ok_nxt;
        width_r   <= width_nxt;
        height_r  <= height_nxt;
        row_r     <= row_nxt;
        col_r     <= col_nxt;
        run_cnt_r <= run_cnt_nxt;
        low_r     <= low_nxt;
      end
      if (!in_stall) begin
        req_valid_r <= accept && emit;
      end
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

endmodule

// ----- rtl/core/srle_clip.sv -----
// Clipper: maps a pixel run onto the frame and drops what falls outside
module srle_clip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  input  srle_pkg::req_t req,
  output logic           req_ready,
  input  logic [11:0]    pos_x,
  input  logic [11:0]    pos_y,
  input  logic [11:0]    frame_lines,
  input  logic [12:0]    pitch,
  output logic           run_valid,
  output srle_pkg::run_t run,
  input  logic           run_ready
);
  import srle_pkg::*;

  logic signed [19:0] x, y, line, lines, pitch_s, wid;
  logic signed [19:0] xsta, xend_a, xend, first, last, lo, hi, len, col;
  logic               line_ok, visible;
  logic               run_valid_r;
  run_t               run_r, run_nxt;

  assign req_ready = !run_valid_r || run_ready;
  assign run_valid = run_valid_r;
  assign run       = run_r;

  // clip window and run bounds
  always_comb begin
    x       = signed'({{8{pos_x[11]}}, pos_x});
    y       = signed'({{8{pos_y[11]}}, pos_y});
    lines   = signed'({8'd0, frame_lines});
    pitch_s = signed'({7'd0, pitch});
    wid     = signed'({4'd0, req.width});
    line    = y + signed'({4'd0, req.row});
    line_ok = !line[19] && (line < lines);
    xsta    = x[19] ? -x : 20'sd0;
    xend_a  = wid - 20'sd1;
    xend    = ((x + xend_a) > (pitch_s - 20'sd1)) ? (pitch_s - 20'sd1 - x) : xend_a;
    first   = signed'({3'd0, req.c0});
    last    = first + signed'({12'd0, req.count}) - 20'sd1;
    lo      = (first < xsta) ? xsta : first;
    hi      = (last > xend) ? xend : last;
    len     = hi - lo + 20'sd1;
    col     = x + lo;
    visible = req.err || (line_ok && !(lo > hi));

    run_nxt.err  = req.err;
    run_nxt.line = req.err ? 12'd0 : line[11:0];
    run_nxt.col  = req.err ? 12'd0 : col[11:0];
    run_nxt.len  = req.err ? 12'd0 : len[11:0];
    run_nxt.pix  = req.err ? 16'd0 : req.pix;
  end

  // clipped run register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
    end else if (req_ready) begin
      run_valid_r <= req_valid && visible;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      run_r <= run_nxt;
    end
  end

endmodule

// ----- rtl/core/srle_emit.sv -----
// Address stage and result register: frame index, doubling and RGB888 color
module srle_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                run_valid,
  input  srle_pkg::run_t      run,
  output logic                run_ready,
  input  logic                double_size,
  input  logic [12:0]         pitch,
  output logic                out_valid,
  input  logic                out_stall,
  output srle_pkg::out_item_t out_item
);
  import srle_pkg::*;

  logic        a_valid_r, a_second_r;
  logic [23:0] a_dest_r;
  logic [11:0] a_len_r;
  logic [15:0] a_pix_r;
  logic        a_err_r, a_dbl_r;
  logic [12:0] a_pitch_r;
  logic [24:0] prod;
  logic        out_free, a_send, a_done;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  assign out_free  = !out_valid_r || !out_stall;
  assign a_send    = a_valid_r && out_free;
  assign a_done    = a_send && (!a_dbl_r || a_second_r);
  assign run_ready = !a_valid_r || a_done;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // row start address
  assign prod = {13'd0, run.line} * {12'd0, pitch};

  // result fields from the address register
  always_comb begin
    if (a_dbl_r) begin
      out_nxt.dest_index = {a_dest_r[22:0], 1'b0} + (a_second_r ? {11'd0, a_pitch_r} : 24'd0);
      out_nxt.run_length = {a_len_r, 1'b0};
    end else begin
      out_nxt.dest_index = a_dest_r;
      out_nxt.run_length = {1'b0, a_len_r};
    end
    out_nxt.red          = {a_pix_r[15:11], 3'd0};
    out_nxt.green        = {a_pix_r[10:5], 2'd0};
    out_nxt.blue         = {a_pix_r[4:0], 3'd0};
    out_nxt.header_error = a_err_r;
    out_nxt.last_of_run  = !a_dbl_r || a_second_r;
  end

  // address stage control; a doubled run stays for two results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      a_second_r <= 1'b0;
    end else if (run_ready) begin
      a_valid_r  <= run_valid;
      a_second_r <= 1'b0;
    end else if (a_send) begin
      a_second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (run_ready && run_valid) begin
      a_dest_r  <= prod[23:0] + {12'd0, run.col};
      a_len_r   <= run.len;
      a_pix_r   <= run.pix;
      a_err_r   <= run.err;
      a_dbl_r   <= double_size && !run.err;
      a_pitch_r <= pitch;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_send) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- rtl/core/splash_rle_rgb565_blitter_unit.sv -----
// Top level of the run-length RGB565 splash blitter with its register port
//
// The input channel takes one byte of a compressed splash file per item;
// first_byte marks header byte 0 and restarts parsing. The result channel
// gives destination runs: frame index, length and an RGB888 color, or one
// header_error item when the magic or bytes-per-dot field is wrong.
// Placement, frame size and 2x2 doubling live in the register port; write
// them only while no item is in flight.
// Throughput: one input item per cycle while in_stall is low. An item that
// yields a doubled run holds the address stage for both its results, one
// after the other, since both share the single result register. Items that
// yield nothing leave no gap. A result passes the request, clip and
// address registers, then the result register. On a receiver stall the
// result register holds and the stall reaches back through full stages at
// once; in_stall rises only with full request, clip and address stages.
// Reset clears the parser to the header phase, empties all stages and
// loads the register defaults (720 x 1280 frame, no offset, no doubling).
module splash_rle_rgb565_blitter_unit #(
  parameter int unsigned MAX_FRAME_COLUMNS = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  srle_pkg::in_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output srle_pkg::out_item_t       out_item,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [srle_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import srle_pkg::*;

  logic [11:0] pos_x_r, pos_y_r, frame_columns_r, frame_lines_r;
  logic        double_size_r;
  logic [2:0]  reg_idx;
  logic        cfg_write;
  logic [12:0] pitch;
  logic        req_valid, req_ready, run_valid, run_ready;
  req_t        req;
  run_t        run;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r         <= 12'd0;
      pos_y_r         <= 12'd0;
      frame_columns_r <= FRAME_COLUMNS_RST;
      frame_lines_r   <= FRAME_LINES_RST;
      double_size_r   <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_POS_X:         pos_x_r         <= pwdata[11:0];
        REG_POS_Y:         pos_y_r         <= pwdata[11:0];
        REG_FRAME_COLUMNS: frame_columns_r <= pwdata[11:0];
        REG_FRAME_LINES:   frame_lines_r   <= pwdata[11:0];
        REG_DOUBLE_SIZE:   double_size_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_POS_X:         prdata = {20'd0, pos_x_r};
      REG_POS_Y:         prdata = {20'd0, pos_y_r};
      REG_FRAME_COLUMNS: prdata = {20'd0, frame_columns_r};
      REG_FRAME_LINES:   prdata = {20'd0, frame_lines_r};
      REG_DOUBLE_SIZE:   prdata = {31'd0, double_size_r};
      default:           prdata = 32'd0;
    endcase
  end

  // row pitch limited to the widest supported frame
  assign pitch = ({1'b0, frame_columns_r} > 13'(MAX_FRAME_COLUMNS)) ?
                 13'(MAX_FRAME_COLUMNS) : {1'b0, frame_columns_r};

  srle_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  srle_clip u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req         (req),
    .req_ready   (req_ready),
    .pos_x       (pos_x_r),
    .pos_y       (pos_y_r),
    .frame_lines (frame_lines_r),
    .pitch       (pitch),
    .run_valid   (run_valid),
    .run         (run),
    .run_ready   (run_ready)
  );

  srle_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .run_valid   (run_valid),
    .run         (run),
    .run_ready   (run_ready),
    .double_size (double_size_r),
    .pitch       (pitch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ----- rtl/core/srle_check.sv -----
// Port checker for the splash blitter, bound to the top level
module srle_check (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input srle_pkg::out_item_t out_item
);
  import srle_pkg::*;

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result dropped or changed under stall");

  // the first half of a doubled run is followed at once by the second
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_of_run |=> out_valid)
    else $error("second result of a doubled run missing");

  // a header error item is a lone, empty result
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.header_error |->
      out_item.last_of_run && (out_item.run_length == 13'd0) &&
      (out_item.dest_index == 24'd0))
    else $error("header error item carries run data");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind splash_rle_rgb565_blitter_unit srle_check u_srle_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
